@@ hdl/dprb_pkg.sv @@
// Package for the decoded picture reorder buffer: sizes, slot and result types,
// and the action codes of the input channel.
// Used by every module under hdl; depends on nothing else.
package dprb_pkg;

  localparam int CAPACITY  = 16;
  localparam int SLOTS     = CAPACITY + 1;
  localparam int IDX_W     = $clog2(SLOTS);
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int ID_W      = 8;
  localparam int ORDER_W   = 32;
  localparam int FILL_W    = 5;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [ID_W-1:0]    buf_id_t;
  typedef logic [ORDER_W-1:0] order_t;

  // Action carried in the input channel's tuser
  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_FLUSH  = 1'b1
  } action_t;

  typedef struct packed {
    order_t  order;
    buf_id_t buf_id;
  } slot_t;

  typedef struct packed {
    logic   en;
    idx_t   addr;
    slot_t  data;
  } mem_wr_t;

  typedef struct packed {
    logic              emitted;
    buf_id_t           buf_id;
    order_t            order;
    logic [FILL_W-1:0] fill;
  } res_t;

endpackage

@@ hdl/dprb_slot_ram.sv @@
// Slot store of the reorder buffer: one write port and one read port with
// registered read data.
// Depends on dprb_pkg.
module dprb_slot_ram (
  input  logic             clk,
  input  dprb_pkg::mem_wr_t wr,
  input  dprb_pkg::idx_t   raddr,
  output dprb_pkg::slot_t  rdata
);
  import dprb_pkg::*;

  slot_t mem_r [SLOTS];
  slot_t rdata_r;

  always_ff @(posedge clk) begin
    if (wr.en && (CNT_W'(wr.addr) < CNT_W'(SLOTS))) begin
      mem_r[wr.addr] <= wr.data;
    end
    // Reads past the last slot only happen speculatively and are discarded.
    if (CNT_W'(raddr) < CNT_W'(SLOTS)) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/dprb_seq.sv @@
// Sequencer of the reorder buffer: appends pictures, scans the slots with one
// shared comparator for the picture to output, then closes up the gap.
// Depends on dprb_pkg; drives the ports of dprb_slot_ram.
module dprb_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dprb_pkg::action_t  in_action,
  input  dprb_pkg::buf_id_t  in_buf_id,
  input  dprb_pkg::order_t   in_order,
  output logic               res_valid,
  input  logic               res_ready,
  output dprb_pkg::res_t     res,
  output dprb_pkg::mem_wr_t  mem_wr,
  output dprb_pkg::idx_t     mem_raddr,
  input  dprb_pkg::slot_t    mem_rdata
);
  import dprb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD0,
    S_FIRST,
    S_SCAN,
    S_SH_START,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  cnt_t   count_r, count_nxt;
  idx_t   pos_r, pos_nxt;
  idx_t   best_idx_r, best_idx_nxt;
  slot_t  best_r, best_nxt;
  logic   emit_r, emit_nxt;

  logic   is_zero;
  logic   is_less;

  // The one shared compare unit: the entry just read against the best so far.
  assign is_zero = (mem_rdata.order == '0);
  assign is_less = (mem_rdata.order < best_r.order);

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    pos_nxt      = pos_r;
    best_idx_nxt = best_idx_r;
    best_nxt     = best_r;
    emit_nxt     = emit_r;
    mem_wr       = '0;
    mem_raddr    = '0;
    in_ready     = 1'b0;
    res_valid    = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_action == ACT_INSERT) begin
            if (count_r < CNT_W'(SLOTS)) begin
              mem_wr.en          = 1'b1;
              mem_wr.addr        = count_r[IDX_W-1:0];
              mem_wr.data.buf_id = in_buf_id;
              mem_wr.data.order  = in_order;
              count_nxt          = count_r + CNT_W'(1);
            end
            if (count_nxt > CNT_W'(CAPACITY)) begin
              state_nxt = S_RD0;
            end else begin
              emit_nxt  = 1'b0;
              best_nxt  = '0;
              state_nxt = S_DONE;
            end
          end else begin
            if (count_r == '0) begin
              emit_nxt  = 1'b0;
              best_nxt  = '0;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_RD0;
            end
          end
        end
      end

      S_RD0: begin
        mem_raddr = '0;
        state_nxt = S_FIRST;
      end

      S_FIRST: begin
        best_nxt     = mem_rdata;
        best_idx_nxt = '0;
        if (count_r > CNT_W'(1)) begin
          mem_raddr = IDX_W'(1);
          pos_nxt   = IDX_W'(1);
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_SH_START;
        end
      end

      S_SCAN: begin
        // An order count of zero opens a new coded sequence and ends the scan.
        if (is_zero) begin
          state_nxt = S_SH_START;
        end else begin
          if (is_less) begin
            best_nxt     = mem_rdata;
            best_idx_nxt = pos_r;
          end
          if (CNT_W'(pos_r) + CNT_W'(1) == count_r) begin
            state_nxt = S_SH_START;
          end else begin
            mem_raddr = pos_r + IDX_W'(1);
            pos_nxt   = pos_r + IDX_W'(1);
          end
        end
      end

      S_SH_START: begin
        mem_raddr = best_idx_r + IDX_W'(1);
        pos_nxt   = best_idx_r;
        emit_nxt  = 1'b1;
        if (CNT_W'(best_idx_r) + CNT_W'(1) >= count_r) begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SHIFT;
        end
      end

      S_SHIFT: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = pos_r;
        mem_wr.data = mem_rdata;
        if (CNT_W'(pos_r) + CNT_W'(2) < count_r) begin
          mem_raddr = pos_r + IDX_W'(2);
          pos_nxt   = pos_r + IDX_W'(1);
        end else begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      emit_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      emit_r  <= emit_nxt;
    end
    pos_r      <= pos_nxt;
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
  end

  assign res.emitted = emit_r;
  assign res.buf_id  = best_r.buf_id;
  assign res.order   = best_r.order;
  assign res.fill    = FILL_W'(count_r);

endmodule

@@ hdl/decoded_picture_reorder_buffer.sv @@
// Top level of the decoded picture reorder buffer: channel packing, the
// output register, and the sequencer and slot store instances.
// Depends on dprb_pkg, dprb_slot_ram and dprb_seq.
//
// Usage. Each input transaction on the in_ channel is one picture event:
// tuser selects insert (0) or flush (1); for an insert, tdata carries the
// buffer handle and its picture order count. Every input transaction gives
// exactly one output transaction on the out_ channel. Its tuser flag says
// whether a picture was removed and output; tdata carries that picture's
// handle and order count (both zero when none) and the number of pictures
// left in the store.
// Timing. An insert that does not overflow the store, or a flush of an empty
// store, has its result go from the sequencer's done state into the output register.
// An item that outputs a picture reads one slot per cycle from the single
// read port, first for the scan with the shared comparator, then for closing
// up the gap. A zero order count that ends the scan, or a chosen picture
// near the newest end, shortens this work. One item is processed at a time;
// in_tready is high only while the sequencer is idle, so a new item is taken
// only after the sequencer has handed on its last result.
// Reset (synchronous, rst_n low) empties the store and the output register.
// When the receiver stalls, the finished result waits in the output
// register; the sequencer accepts and processes the next item and then
// holds its own result until the register is free.
module decoded_picture_reorder_buffer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] buffer_id, [39:8] order_count
  input  logic [0:0]  in_tuser,   // [0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [7:0] out_buffer_id, [39:8] out_order_count,
                                  // [44:40] fill_level, [47:45] zero
  output logic [0:0]  out_tuser   // [0] emitted
);
  import dprb_pkg::*;

  res_t    seq_res;
  logic    seq_res_valid;
  logic    seq_res_ready;
  mem_wr_t mem_wr;
  idx_t    mem_raddr;
  slot_t   mem_rdata;
  action_t in_action;

  res_t    out_res_r;
  logic    out_valid_r;

  assign in_action = action_t'(in_tuser[0]);

  dprb_slot_ram u_ram (
    .clk   (clk),
    .wr    (mem_wr),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  dprb_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_action (in_action),
    .in_buf_id (in_tdata[ID_W-1:0]),
    .in_order  (in_tdata[ID_W+ORDER_W-1:ID_W]),
    .res_valid (seq_res_valid),
    .res_ready (seq_res_ready),
    .res       (seq_res),
    .mem_wr    (mem_wr),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // The output register takes a new result when it is empty or being drained.
  assign seq_res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (seq_res_ready) begin
      out_valid_r <= seq_res_valid;
    end
    if (seq_res_ready && seq_res_valid) begin
      out_res_r <= seq_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.emitted;
  assign out_tdata  = {3'b000, out_res_r.fill, out_res_r.order, out_res_r.buf_id};

endmodule

@@ tb/decoded_picture_reorder_buffer_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for decoded_picture_reorder_buffer: a directed table and then random
// picture streams, checked against their typed result or the bumping model kept in this file.
// Depends on dprb_pkg and the RTL under hdl.
module decoded_picture_reorder_buffer_tb;
  import dprb_pkg::*;

  localparam int RANDOM_ITEMS = 1500;
  // No idling on either side during the last stretch of random items.
  localparam int CALM_ITEMS   = 200;
  // Cycles without any transaction before the run is declared hung.
  localparam int STALL_LIMIT  = 2000;
  // Settling time after the last result, above the worst item latency.
  localparam int DRAIN_CYCLES = 60;

  localparam res_t UNTYPED = '0;

  // One row of the directed table. A row is repeated reps times. On each repeat the handle
  // goes up by one and the order count moves by poc_step. Rows with typed set carry their
  // expected result. All other rows are checked against the model.
  typedef struct {
    action_t act;
    buf_id_t id;
    order_t  poc;
    int      reps;
    int      poc_step;
    bit      typed;
    res_t    want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // [7:0] buffer_id, [39:8] order_count
  logic [0:0]  in_tuser;   // [0] action
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // [7:0] out_buffer_id, [39:8] out_order_count, [44:40] fill_level
  logic [0:0]  out_tuser;  // [0] emitted

  // Model of the store: handles and order counts, oldest first.
  buf_id_t held_ids [SLOTS];
  order_t  held_pocs[SLOTS];
  int      held = 0;

  // Expected output transactions, oldest first.
  res_t    expected_outputs[$];
  int      failures = 0;
  int      rx_hold = 0;
  int      idle_cycles = 0;
  bit      calm = 1'b0;
  bit      quiet = 1'b0;

  stim_row_t directed[18];

  decoded_picture_reorder_buffer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Choose the picture to output, then remove it. The scan begins at the oldest entry and
  // keeps the lowest order count. On a tie the older entry stays chosen. The scan stops at
  // the first later entry whose count is zero, because that entry opens a new coded
  // sequence. The entries after the removed one then move up to close the gap.
  function automatic bit bump_picture(output buf_id_t id, output order_t poc);
    int best;
    best = 0;
    id   = '0;
    poc  = '0;
    if (held == 0) return 1'b0;
    for (int i = 1; i < held; i++) begin
      if (held_pocs[i] == '0) break;
      if (held_pocs[i] < held_pocs[best]) best = i;
    end
    id  = held_ids[best];
    poc = held_pocs[best];
    for (int i = best; i + 1 < held; i++) begin
      held_ids[i]  = held_ids[i + 1];
      held_pocs[i] = held_pocs[i + 1];
    end
    held--;
    return 1'b1;
  endfunction

  // Work out the result of one picture event and update the model store.
  // An insert outputs a picture only when the store would otherwise exceed its capacity.
  function automatic res_t predict_picture_out(action_t act, buf_id_t id, order_t poc);
    res_t    r;
    buf_id_t out_id;
    order_t  out_poc;
    bit      hit;
    hit = 1'b0;
    if (act == ACT_INSERT) begin
      if (held < SLOTS) begin
        held_ids[held]  = id;
        held_pocs[held] = poc;
        held++;
      end
      if (held > CAPACITY) hit = bump_picture(out_id, out_poc);
    end else begin
      hit = bump_picture(out_id, out_poc);
    end
    r.emitted = hit;
    r.buf_id  = hit ? out_id : '0;
    r.order   = hit ? out_poc : '0;
    r.fill    = FILL_W'(held);
    return r;
  endfunction

  // Offer one picture event and hold it until the block accepts it. In the step in which the
  // transaction is accepted, valid either stays high for the next call or drops for a short
  // random gap. Nothing drives it twice in one step.
  task automatic send_picture_event(action_t act, buf_id_t id, order_t poc, bit typed,
                                    res_t want);
    res_t predicted;
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {poc, id};
    do @(posedge clk); while (!in_tready);
    predicted = predict_picture_out(act, id, poc);
    expected_outputs.push_back(typed ? want : predicted);
    if (!calm && !quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Receiver side. The block sees random tready stalls, except in quiet stretches
  // and in the calm tail of the run.
  always @(posedge clk) begin
    if (rx_hold != 0) begin
      out_tready <= 1'b0;
      rx_hold    <= rx_hold - 1;
    end else if (!calm && !quiet && $urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      rx_hold    <= $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each output transaction, field by field, with the oldest expectation.
  always @(posedge clk) begin : check_outputs
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_outputs.size() == 0) begin
        $error("output transaction with no expected result waiting");
        failures++;
      end else begin
        want = expected_outputs.pop_front();
        if (out_tuser[0] !== want.emitted) begin
          $error("emitted: expected %0d, actual %0d", want.emitted, out_tuser[0]);
          failures++;
        end
        if (out_tdata[7:0] !== want.buf_id) begin
          $error("out_buffer_id: expected %0d, actual %0d", want.buf_id, out_tdata[7:0]);
          failures++;
        end
        if (out_tdata[39:8] !== want.order) begin
          $error("out_order_count: expected %0d, actual %0d", want.order, out_tdata[39:8]);
          failures++;
        end
        if (out_tdata[44:40] !== want.fill) begin
          $error("fill_level: expected %0d, actual %0d", want.fill, out_tdata[44:40]);
          failures++;
        end
      end
    end
  end

  // Watchdog. It counts the cycles after reset in which neither channel completes a
  // transaction.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("decoded_picture_reorder_buffer verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int      rand_left;
    int      mode;
    int      len;
    action_t act;
    buf_id_t id;
    order_t  poc;
    order_t  base;

    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= ACT_INSERT;

    // Directed part. It covers empty flushes, handles and order counts at their extremes,
    // a zero count that ends the scan, and a zero count in the oldest entry. It also covers
    // ties between equal counts, filling the store to capacity, inserts that overflow it,
    // and draining the store to empty.
    directed = '{
      '{ACT_FLUSH,  8'h00, 32'h0000_0000,  1,   0, 1'b1, '{1'b0, 8'h00, 32'h0000_0000, 5'd0}},
      '{ACT_INSERT, 8'hFF, 32'hFFFF_FFFF,  1,   0, 1'b1, '{1'b0, 8'h00, 32'h0000_0000, 5'd1}},
      '{ACT_INSERT, 8'h00, 32'h0000_0000,  1,   0, 1'b1, '{1'b0, 8'h00, 32'h0000_0000, 5'd2}},
      '{ACT_FLUSH,  8'hA5, 32'h1234_5678,  1,   0, 1'b1, '{1'b1, 8'hFF, 32'hFFFF_FFFF, 5'd1}},
      '{ACT_FLUSH,  8'h5A, 32'h8765_4321,  1,   0, 1'b1, '{1'b1, 8'h00, 32'h0000_0000, 5'd0}},
      '{ACT_INSERT, 8'h01, 32'h0000_0000,  1,   0, 1'b0, UNTYPED},
      '{ACT_INSERT, 8'h02, 32'h0000_0008,  1,   0, 1'b0, UNTYPED},
      '{ACT_INSERT, 8'h03, 32'h0000_0004,  1,   0, 1'b0, UNTYPED},
      '{ACT_INSERT, 8'h04, 32'h0000_0004,  1,   0, 1'b0, UNTYPED},
      '{ACT_FLUSH,  8'h00, 32'h0000_0000,  4,   0, 1'b0, UNTYPED},
      '{ACT_INSERT, 8'h10, 32'd1000,      16, -10, 1'b0, UNTYPED},
      '{ACT_INSERT, 8'hC8, 32'h0000_0005,  1,   0, 1'b0, UNTYPED},
      '{ACT_INSERT, 8'hC9, 32'h0000_0000,  1,   0, 1'b0, UNTYPED},
      '{ACT_INSERT, 8'hCA, 32'hFFFF_FFFF,  1,   0, 1'b0, UNTYPED},
      '{ACT_FLUSH,  8'h33, 32'hDEAD_BEEF, 17,   1, 1'b0, UNTYPED},
      '{ACT_INSERT, 8'h55, 32'hAAAA_AAAA,  1,   0, 1'b0, UNTYPED},
      '{ACT_INSERT, 8'hAA, 32'h5555_5555,  1,   0, 1'b0, UNTYPED},
      '{ACT_FLUSH,  8'h00, 32'h0000_0000,  3,   0, 1'b0, UNTYPED}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[r]) begin
      for (int k = 0; k < directed[r].reps; k++) begin
        send_picture_event(directed[r].act, buf_id_t'(directed[r].id + k),
                           directed[r].poc + order_t'(k * directed[r].poc_step),
                           directed[r].typed, directed[r].want);
      end
    end

    // Random part. Most runs are decoded pictures in decode order. Their counts sit in a
    // window that moves forward, now and then a sequence restarts at zero, and a few
    // flushes are mixed in. These runs keep the store near capacity, so inserts overflow it
    // often. Drain runs empty the store. Noise runs use fully random fields, and some runs
    // use extreme counts.
    base      = '0;
    rand_left = RANDOM_ITEMS;
    while (rand_left > 0) begin
      mode = $urandom_range(0, 9);
      len  = (mode < 6) ? $urandom_range(1, 24) : $urandom_range(1, 18);
      if (mode < 6) begin
        case ($urandom_range(0, 7))
          0:       base = $urandom;
          1:       base = 32'hFFFF_FFF0;
          default: ;
        endcase
      end
      for (int j = 0; j < len && rand_left > 0; j++) begin
        id  = buf_id_t'($urandom_range(0, 255));
        act = ACT_INSERT;
        poc = $urandom;
        if (mode < 6) begin
          if ($urandom_range(0, 5) == 0) begin
            act = ACT_FLUSH;
          end else if ($urandom_range(0, 15) == 0) begin
            poc  = '0;
            base = '0;
          end else begin
            poc  = base + order_t'($urandom_range(1, 16));
            base = base + order_t'($urandom_range(0, 4));
          end
        end else if (mode < 8) begin
          act = ACT_FLUSH;
        end else if (mode == 8) begin
          act = action_t'($urandom_range(0, 1));
        end else begin
          case ($urandom_range(0, 2))
            0:       poc = '0;
            1:       poc = '1;
            default: ;
          endcase
        end
        calm = (rand_left <= CALM_ITEMS);
        if ($urandom_range(0, 39) == 0) quiet = !quiet;
        send_picture_event(act, id, poc, 1'b0, UNTYPED);
        rand_left--;
      end
    end

    // All events are in. Wait for the last results, then give the block time to show any
    // output transaction that should not appear.
    in_tvalid <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0 && expected_outputs.size() == 0) begin
      $display("decoded_picture_reorder_buffer verification clean");
    end else begin
      $display("decoded_picture_reorder_buffer verification failed");
    end
    $finish;
  end

endmodule
